FILE: rtl/segmented_word_memory_defines.svh
// Assertion macros used by the checker file of segmented_word_memory.
`ifndef SEGMENTED_WORD_MEMORY_DEFINES_SVH
`define SEGMENTED_WORD_MEMORY_DEFINES_SVH

// Checked on every edge outside reset.
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/swm_pkg.sv
// Package of segmented_word_memory: address map, codes and shared types.
package swm_pkg;

  localparam int STACK_DEPTH_DEF  = 8192;
  localparam int HEAP_DEPTH_DEF   = 8192;
  localparam int STATIC_DEPTH_DEF = 1024;
  localparam int MMIO_DEPTH_DEF   = 4;

  localparam logic [31:0] STACK_TOP   = 32'h7fffeffc;
  localparam logic [31:0] STACK_FLOOR = 32'h7fff6ffc;
  localparam logic [31:0] HEAP_BASE   = 32'h10008000;
  localparam logic [31:0] HEAP_END    = 32'h1000ffff;
  localparam logic [31:0] STATIC_BASE = 32'h10010000;
  localparam logic [31:0] STATIC_END  = 32'h10010fa0;
  localparam logic [31:0] MMIO_BASE   = 32'hffff0000;
  localparam logic [31:0] MMIO_END    = 32'hffff0010;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_UNMAPPED   = 2'd2;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_STACK,
    SEG_HEAP,
    SEG_STATIC,
    SEG_MMIO
  } seg_t;

  typedef struct packed {
    seg_t       seg;
    logic [1:0] status;
  } decode_t;

endpackage

FILE: rtl/segmented_word_memory.sv
// Top level of segmented_word_memory: segment memories, clear sweep, pipeline.
//
// Request channel (req_valid / req_stall): func, address, write_data.
// Response channel (rsp_valid / rsp_stall): read_data, status.
// A transaction moves at an edge with valid high and stall low.
// Every request gives exactly one response, in request order.
// A response is read synchronously from memory at the accepting edge,
// then passes one output register; a response stall can hold it between.
// Throughput: one request per cycle while req_stall is low, set by the single memory port
// cycle of each segment memory; stack, heap and static are RAMs.
// Reset: the MMIO words clear at once; the stack, heap and static memories
// are swept to zero, one word of each per cycle, while the sweep counter
// runs over max(STACK_DEPTH, HEAP_DEPTH, STATIC_DEPTH) addresses (8192 by
// default), and req_stall stays high during the sweep.
// Stall: while rsp_stall holds a waiting response, one more request may be
// taken into the read stage; after that req_stall rises until the
// response is taken.
module segmented_word_memory #(
  parameter int STACK_DEPTH  = swm_pkg::STACK_DEPTH_DEF,
  parameter int HEAP_DEPTH   = swm_pkg::HEAP_DEPTH_DEF,
  parameter int STATIC_DEPTH = swm_pkg::STATIC_DEPTH_DEF,
  parameter int MMIO_DEPTH   = swm_pkg::MMIO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        func,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] read_data,
  output logic [1:0]  status
);
  import swm_pkg::*;

  localparam int STACK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int HEAP_AW   = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int STATIC_AW = (STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1;
  localparam int MMIO_AW   = $clog2(MMIO_DEPTH);
  localparam int CLR_DEPTH_SH = (STACK_DEPTH > HEAP_DEPTH) ? STACK_DEPTH : HEAP_DEPTH;
  localparam int CLR_DEPTH = (CLR_DEPTH_SH > STATIC_DEPTH) ? CLR_DEPTH_SH : STATIC_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH + 1);

  logic [31:0] stack_mem  [STACK_DEPTH];
  logic [31:0] heap_mem   [HEAP_DEPTH];
  logic [31:0] static_mem [STATIC_DEPTH];
  logic [31:0] mmio_regs  [MMIO_DEPTH];

  decode_t     dec;
  logic [29:0] word_off;
  logic        accept;
  logic        wr_ok;

  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;

  logic                 stack_we;
  logic [STACK_AW-1:0]  stack_waddr;
  logic                 heap_we;
  logic [HEAP_AW-1:0]   heap_waddr;
  logic                 static_we;
  logic [STATIC_AW-1:0] static_waddr;
  logic [31:0]          mem_wdata;

  logic [31:0] stack_rdata;
  logic [31:0] heap_rdata;
  logic [31:0] static_rdata;
  logic [31:0] mmio_rdata;

  logic        p1_valid;
  logic        p1_func;
  decode_t     p1_dec;
  logic        p1_adv;
  logic [31:0] seg_rdata;
  logic [31:0] rsp_data_next;

  swm_decode #(
    .STACK_DEPTH  (STACK_DEPTH),
    .HEAP_DEPTH   (HEAP_DEPTH),
    .STATIC_DEPTH (STATIC_DEPTH),
    .MMIO_DEPTH   (MMIO_DEPTH)
  ) u_decode (
    .address  (address),
    .dec      (dec),
    .word_off (word_off)
  );

  assign p1_adv    = p1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = clearing || (p1_valid && rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign wr_ok     = accept && (func == FUNC_WRITE) && (dec.status == ST_OK);

  // zero sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign mem_wdata    = clearing ? 32'd0 : write_data;
  assign stack_we     = clearing ? (clr_cnt < CLR_W'(STACK_DEPTH))
                                 : (wr_ok && dec.seg == SEG_STACK);
  assign heap_we      = clearing ? (clr_cnt < CLR_W'(HEAP_DEPTH))
                                 : (wr_ok && dec.seg == SEG_HEAP);
  assign static_we    = clearing ? (clr_cnt < CLR_W'(STATIC_DEPTH))
                                 : (wr_ok && dec.seg == SEG_STATIC);
  assign stack_waddr  = clearing ? clr_cnt[STACK_AW-1:0] : word_off[STACK_AW-1:0];
  assign heap_waddr   = clearing ? clr_cnt[HEAP_AW-1:0] : word_off[HEAP_AW-1:0];
  assign static_waddr = clearing ? clr_cnt[STATIC_AW-1:0] : word_off[STATIC_AW-1:0];

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= mem_wdata;
    end
    if (accept) begin
      stack_rdata <= stack_mem[word_off[STACK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= mem_wdata;
    end
    if (accept) begin
      heap_rdata <= heap_mem[word_off[HEAP_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (static_we) begin
      static_mem[static_waddr] <= mem_wdata;
    end
    if (accept) begin
      static_rdata <= static_mem[word_off[STATIC_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MMIO_DEPTH; i++) begin
        mmio_regs[i] <= '0;
      end
    end else if (wr_ok && dec.seg == SEG_MMIO) begin
      mmio_regs[word_off[MMIO_AW-1:0]] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mmio_rdata <= mmio_regs[word_off[MMIO_AW-1:0]];
      p1_func    <= func;
      p1_dec     <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_comb begin
    case (p1_dec.seg)
      SEG_STACK:  seg_rdata = stack_rdata;
      SEG_HEAP:   seg_rdata = heap_rdata;
      SEG_STATIC: seg_rdata = static_rdata;
      SEG_MMIO:   seg_rdata = mmio_rdata;
      default:    seg_rdata = '1;
    endcase
    if (p1_func == FUNC_WRITE) begin
      rsp_data_next = '0;
    end else if (p1_dec.status != ST_OK) begin
      rsp_data_next = '1;
    end else begin
      rsp_data_next = seg_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      read_data <= rsp_data_next;
      status    <= p1_dec.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (p1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/swm_decode.sv
// Address decoder: segment, status and word offset of one access.
module swm_decode #(
  parameter int STACK_DEPTH  = swm_pkg::STACK_DEPTH_DEF,
  parameter int HEAP_DEPTH   = swm_pkg::HEAP_DEPTH_DEF,
  parameter int STATIC_DEPTH = swm_pkg::STATIC_DEPTH_DEF,
  parameter int MMIO_DEPTH   = swm_pkg::MMIO_DEPTH_DEF
) (
  input  logic [31:0]      address,
  output swm_pkg::decode_t dec,
  output logic [29:0]      word_off
);
  import swm_pkg::*;

  logic [31:0] stack_diff;
  logic [31:0] heap_diff;
  logic [31:0] static_diff;
  logic [31:0] mmio_diff;

  assign stack_diff  = STACK_TOP - address;
  assign heap_diff   = address - HEAP_BASE;
  assign static_diff = address - STATIC_BASE;
  assign mmio_diff   = address - MMIO_BASE;

  always_comb begin
    dec.seg    = SEG_NONE;
    dec.status = ST_UNMAPPED;
    word_off   = '0;
    if (address[1:0] != 2'b00) begin
      dec.status = ST_MISALIGNED;
    end else if (address <= STACK_TOP && address > STACK_FLOOR) begin
      word_off = stack_diff[31:2];
      if (stack_diff[31:2] < 30'(STACK_DEPTH)) begin
        dec.seg    = SEG_STACK;
        dec.status = ST_OK;
      end
    end else if (address >= HEAP_BASE && address < HEAP_END) begin
      word_off = heap_diff[31:2];
      if (heap_diff[31:2] < 30'(HEAP_DEPTH)) begin
        dec.seg    = SEG_HEAP;
        dec.status = ST_OK;
      end
    end else if (address >= STATIC_BASE && address < STATIC_END) begin
      word_off = static_diff[31:2];
      if (static_diff[31:2] < 30'(STATIC_DEPTH)) begin
        dec.seg    = SEG_STATIC;
        dec.status = ST_OK;
      end
    end else if (address >= MMIO_BASE && address < MMIO_END) begin
      word_off = mmio_diff[31:2];
      if (mmio_diff[31:2] < 30'(MMIO_DEPTH)) begin
        dec.seg    = SEG_MMIO;
        dec.status = ST_OK;
      end
    end
  end

endmodule

FILE: rtl/swm_checker.sv
// Port-level checker of segmented_word_memory and its bind.
`include "segmented_word_memory_defines.svh"

module swm_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] read_data,
  input logic [1:0]  status
);
  import swm_pkg::*;

  `SWM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(status), "stalled response changed")
  `SWM_ASSERT(a_status_code, rsp_valid |-> status <= ST_UNMAPPED, "undefined status code")
  `SWM_ASSERT(a_fail_data, rsp_valid && status != ST_OK |-> read_data == 32'd0 || read_data == 32'hffffffff, "refused access returned a data word")
  `SWM_ASSERT_ALWAYS(a_reset_quiet, rst |=> req_stall && !rsp_valid, "block not quiet after reset")

endmodule

bind segmented_word_memory swm_checker u_swm_checker (.*);
